[design/cpf_pkg.sv]
// ---------------------------------------------------------------------------
// cpf_pkg
// Shared types, character codes and mod-11 helpers for the CPF validator.
// ---------------------------------------------------------------------------
package cpf_pkg;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [3:0] NUM_DIGITS = 4'd11;
  localparam logic [3:0] COUNT_SAT  = 4'd12;
  localparam logic [3:0] FIRST_LEN  = 4'd9;
  localparam logic [3:0] SECOND_LEN = 4'd10;
  localparam logic [3:0] WEIGHT1_TOP = 4'd10;
  localparam logic [3:0] WEIGHT2_TOP = 4'd11;

  // Character classes decided by the front end
  localparam logic [1:0] KIND_SEP   = 2'd0;
  localparam logic [1:0] KIND_DIGIT = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
    logic       last;
  } cpf_item_t;

  // x mod 11 for an 8-bit value: reciprocal multiply, then one correction
  function automatic logic [3:0] mod11(input logic [7:0] x);
    logic [16:0] prod;
    logic [4:0]  quo;
    logic [8:0]  rem;
    prod = 17'(x) * 17'd373;
    quo  = prod[16:12];
    rem  = 9'(x) - 9'(quo) * 9'd11;
    if (rem >= 9'd11) begin
      rem = rem - 9'd11;
    end
    return rem[3:0];
  endfunction

  // (sum*10) mod 11 with 10 mapped to 0, from the residue m = sum mod 11
  function automatic logic [3:0] check_of(input logic [3:0] m);
    logic [3:0] r;
    if (m == 4'd0 || m == 4'd1) begin
      r = 4'd0;
    end else begin
      r = 4'd11 - m;
    end
    return r;
  endfunction

endpackage

[design/cpf_if.sv]
// ---------------------------------------------------------------------------
// cpf_char_if / cpf_res_if
// Valid/ready channels for the character stream and the verdict stream.
// ---------------------------------------------------------------------------
interface cpf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface cpf_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

[design/cpf_front.sv]
// ---------------------------------------------------------------------------
// cpf_front
// Classify each incoming character and push it into the queue.
// ---------------------------------------------------------------------------
module cpf_front (
  input  logic             rst,
  cpf_char_if.sink         char_in,
  output logic             push_valid,
  input  logic             push_ready,
  output cpf_pkg::cpf_item_t push_item
);
  import cpf_pkg::*;

  logic is_sep;
  logic is_digit;

  assign is_sep   = (char_in.char_code == CH_DOT) || (char_in.char_code == CH_DASH);
  assign is_digit = (char_in.char_code >= CH_ZERO) && (char_in.char_code <= CH_NINE);

  always_comb begin
    push_item.digit = char_in.char_code[3:0];
    push_item.last  = char_in.last;
    priority if (is_sep) begin
      push_item.kind = KIND_SEP;
    end else if (is_digit) begin
      push_item.kind = KIND_DIGIT;
    end else begin
      push_item.kind = KIND_BAD;
    end
  end

  // Drop traffic while reset is held
  assign push_valid    = char_in.valid & ~rst;
  assign char_in.ready = push_ready & ~rst;

endmodule

[design/cpf_queue.sv]
// ---------------------------------------------------------------------------
// cpf_queue
// Small FIFO of classified characters between front and back.
// ---------------------------------------------------------------------------
module cpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  cpf_pkg::cpf_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cpf_pkg::cpf_item_t pop_item
);
  import cpf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpf_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/cpf_back.sv]
// ---------------------------------------------------------------------------
// cpf_back
// Accumulate digit state, decide the verdict on the last character.
// ---------------------------------------------------------------------------
module cpf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cpf_pkg::cpf_item_t pop_item,
  cpf_res_if.source          res_out
);
  import cpf_pkg::*;

  logic [3:0] digit_count,    digit_count_next;
  logic [3:0] first_digit,    first_digit_next;
  logic       all_same,       all_same_next;
  logic       bad_char,       bad_char_next;
  logic [3:0] sum_first,      sum_first_next;   // residue mod 11
  logic [3:0] sum_second,     sum_second_next;  // residue mod 11
  logic [3:0] tenth_digit,    tenth_digit_next;
  logic [3:0] eleventh_digit, eleventh_digit_next;
  logic       out_valid;
  logic       out_data;
  logic       do_pop;
  logic       verdict;
  logic [7:0] term_first;
  logic [7:0] term_second;

  assign pop_ready = ~out_valid | res_out.ready;
  assign do_pop    = pop_valid & pop_ready;

  assign term_first  = 8'(pop_item.digit) * 8'(WEIGHT1_TOP - digit_count) + 8'(sum_first);
  assign term_second = 8'(pop_item.digit) * 8'(WEIGHT2_TOP - digit_count) + 8'(sum_second);

  always_comb begin
    digit_count_next    = digit_count;
    first_digit_next    = first_digit;
    all_same_next       = all_same;
    bad_char_next       = bad_char;
    sum_first_next      = sum_first;
    sum_second_next     = sum_second;
    tenth_digit_next    = tenth_digit;
    eleventh_digit_next = eleventh_digit;
    unique case (pop_item.kind)
      KIND_SEP: begin
      end
      KIND_DIGIT: begin
        if (digit_count == 4'd0) begin
          first_digit_next = pop_item.digit;
        end else if (digit_count < NUM_DIGITS && pop_item.digit != first_digit) begin
          all_same_next = 1'b0;
        end
        if (digit_count < FIRST_LEN) begin
          sum_first_next = mod11(term_first);
        end
        if (digit_count < SECOND_LEN) begin
          sum_second_next = mod11(term_second);
        end
        if (digit_count == FIRST_LEN) begin
          tenth_digit_next = pop_item.digit;
        end
        if (digit_count == SECOND_LEN) begin
          eleventh_digit_next = pop_item.digit;
        end
        if (digit_count < COUNT_SAT) begin
          digit_count_next = digit_count + 1'b1;
        end
      end
      default: begin
        bad_char_next = 1'b1;
      end
    endcase
  end

  assign verdict = (digit_count_next == NUM_DIGITS) && !bad_char_next && !all_same_next &&
                   (check_of(sum_first_next) == tenth_digit_next) &&
                   (check_of(sum_second_next) == eleventh_digit_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count    <= '0;
      first_digit    <= '0;
      all_same       <= 1'b1;
      bad_char       <= 1'b0;
      sum_first      <= '0;
      sum_second     <= '0;
      tenth_digit    <= '0;
      eleventh_digit <= '0;
    end else if (do_pop) begin
      if (pop_item.last) begin
        digit_count    <= '0;
        first_digit    <= '0;
        all_same       <= 1'b1;
        bad_char       <= 1'b0;
        sum_first      <= '0;
        sum_second     <= '0;
        tenth_digit    <= '0;
        eleventh_digit <= '0;
      end else begin
        digit_count    <= digit_count_next;
        first_digit    <= first_digit_next;
        all_same       <= all_same_next;
        bad_char       <= bad_char_next;
        sum_first      <= sum_first_next;
        sum_second     <= sum_second_next;
        tenth_digit    <= tenth_digit_next;
        eleventh_digit <= eleventh_digit_next;
      end
    end
  end

  // Output register: hold the verdict until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop && pop_item.last) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) begin
      out_data <= verdict;
    end
  end

  assign res_out.valid     = out_valid;
  assign res_out.valid_res = out_data;

endmodule

[design/cpf_check_digit_validator_core.sv]
// ---------------------------------------------------------------------------
// cpf_check_digit_validator_core
// CPF mod-11 check-digit validator over a character stream.
// ---------------------------------------------------------------------------
// Verdict path: the last character is written into the queue, the back end
//   pops it and registers the verdict in the output register, which offers
//   it until a ready receiver takes it.
// Throughput: 1 character per cycle while the queue is not full.
// Reset: synchronous rst empties the queue, clears the digit state and drops
//   the output; no characters are taken while rst is high.
// ---------------------------------------------------------------------------
module cpf_check_digit_validator_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  cpf_char_if.sink  char_in,
  cpf_res_if.source res_out
);
  import cpf_pkg::*;

  // Front end -> queue
  logic      push_valid;
  logic      push_ready;
  cpf_item_t push_item;

  // Queue -> back end
  logic      pop_valid;
  logic      pop_ready;
  cpf_item_t pop_item;

  // Classify each character as separator, digit or bad character.
  cpf_front u_front (
    .rst        (rst),
    .char_in    (char_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple the input transaction from a stalled verdict: the front end keeps
  // taking characters while the back end waits on the output, until the queue fills.
  cpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Advance the running sums (kept as residues mod 11), the count, the first
  // digit and the stored check digits; on the last character, register the
  // verdict and return the state to its reset values.
  cpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .res_out   (res_out)
  );

endmodule

[design/cpf_checker.sv]
// ---------------------------------------------------------------------------
// cpf_checker
// Port-level checks on the validator's channels, bound to the top level.
// ---------------------------------------------------------------------------
module cpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_data
);

  logic [7:0] pending;  // last characters taken whose verdict is not yet taken
  logic       in_done;
  logic       out_done;

  assign in_done  = in_valid & in_ready & in_last;
  assign out_done = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_done && !out_done) begin
      pending <= pending + 1'b1;
    end else if (out_done && !in_done) begin
      pending <= pending - 1'b1;
    end
  end

  // Hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled verdict changed");

  // No verdict without a finished identifier
  a_out_has_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("verdict without a last character");

  // No verdict right after reset
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("verdict present right after reset");

  // No transaction is taken while reset is held
  a_no_accept_in_reset: assert property (@(posedge clk)
    rst |-> !in_ready)
    else $error("input ready during reset");

endmodule

bind cpf_check_digit_validator_core cpf_checker u_cpf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (char_in.valid),
  .in_ready  (char_in.ready),
  .in_last   (char_in.last),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_data  (res_out.valid_res)
);
